@@ design/ring_fifo_with_match_update_top_macros.svh @@
// assertion macros shared by the ring fifo rtl files
// relies on a clock named clk and an active-low reset named arst_n in the using module
`ifndef RING_FIFO_WITH_MATCH_UPDATE_TOP_MACROS_SVH
`define RING_FIFO_WITH_MATCH_UPDATE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define RFMU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define RFMU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RFMU_ASSERT_IMP(lbl, ante, cons, msg)
`define RFMU_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/rfmu_pkg.sv @@
// shared codes and controller/datapath interface types for the ring fifo
// no dependencies
`default_nettype none

package rfmu_pkg;

	// action codes of an input transaction
	localparam logic [1:0] ACT_PUSH   = 2'd0;
	localparam logic [1:0] ACT_POP    = 2'd1;
	localparam logic [1:0] ACT_UPDATE = 2'd2;

	// status codes of a result transaction
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	// commands from controller to datapath
	typedef struct packed {
		logic       capture;
		logic       do_push;
		logic       do_pop;
		logic       scan_start;
		logic       scan_step;
		logic       upd_write;
		logic       head_read;
		logic       status_wr;
		logic [1:0] status;
		logic       load_result;
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic hit;
		logic last;
	} dp_stat_t;

endpackage

`default_nettype wire

@@ design/rfmu_ram.sv @@
// generic single-write single-read ram with registered read data
// no dependencies
`default_nettype none

module rfmu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds when not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ design/rfmu_dp.sv @@
// ring fifo datapath: pointers, count, entry ram, search pipeline and result register
// depends on rfmu_pkg and rfmu_ram
`default_nettype none
`include "ring_fifo_with_match_update_top_macros.svh"

module rfmu_dp #(
	parameter int DEPTH      = 128,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [31:0]       item_value,
	input  wire logic [31:0]       replacement_value,
	input  wire rfmu_pkg::dp_cmd_t cmd,
	output rfmu_pkg::dp_stat_t     stat,
	output logic [1:0]             status,
	output logic [31:0]            head_value,
	output logic [7:0]             occupancy,
	output logic                   is_empty,
	output logic                   is_full
);

	import rfmu_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [AW-1:0]         head_q, tail_q, scan_ptr_q, cmp_addr_s1;
	logic [CW-1:0]         count_q, issue_n_q, cmp_n_q;
	logic                  vld_s1;
	logic [DATA_WIDTH-1:0] key_q, repl_q, in_word, rd_data, wr_data;
	logic [AW-1:0]         rd_addr, wr_addr;
	logic                  rd_en, wr_en, issue_more;
	logic [1:0]            status_q;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
		ring_next = (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
	endfunction

	assign in_word = DATA_WIDTH'(item_value);

	// flags for the controller
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.hit   = vld_s1 && (rd_data == key_q);
	assign stat.last  = vld_s1 && ((cmp_n_q + CW'(1)) == count_q);

	// ram port selection
	assign issue_more = (issue_n_q != count_q);
	assign rd_en      = cmd.head_read | (cmd.scan_step & issue_more);
	assign rd_addr    = cmd.head_read ? head_q : scan_ptr_q;
	assign wr_en      = cmd.do_push | cmd.upd_write;
	assign wr_addr    = cmd.upd_write ? cmp_addr_s1 : tail_q;
	assign wr_data    = cmd.upd_write ? repl_q : in_word;

	rfmu_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// head, tail and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (cmd.do_push) begin
				tail_q  <= ring_next(tail_q);
				count_q <= count_q + CW'(1);
			end else if (cmd.do_pop) begin
				head_q  <= ring_next(head_q);
				count_q <= count_q - CW'(1);
			end
		end
	end

	// captured operands
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q  <= in_word;
			repl_q <= DATA_WIDTH'(replacement_value);
		end
	end

	// search walk: issue one read per cycle, compare the read data in the following cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_ptr_q <= '0;
			issue_n_q  <= '0;
			cmp_n_q    <= '0;
			vld_s1     <= 1'b0;
		end else if (cmd.scan_start) begin
			scan_ptr_q <= head_q;
			issue_n_q  <= '0;
			cmp_n_q    <= '0;
			vld_s1     <= 1'b0;
		end else if (cmd.scan_step) begin
			vld_s1 <= issue_more;
			if (issue_more) begin
				scan_ptr_q <= ring_next(scan_ptr_q);
				issue_n_q  <= issue_n_q + CW'(1);
			end
			if (vld_s1) begin
				cmp_n_q <= cmp_n_q + CW'(1);
			end
		end
	end

	// slot address that travels with the read data
	always_ff @(posedge clk) begin
		if (cmd.scan_step && issue_more) begin
			cmp_addr_s1 <= scan_ptr_q;
		end
	end

	// status of the transaction in progress
	always_ff @(posedge clk) begin
		if (cmd.status_wr) begin
			status_q <= cmd.status;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.load_result) begin
			status     <= status_q;
			head_value <= stat.empty ? 32'd0 : 32'(rd_data);
			occupancy  <= 8'(count_q);
			is_empty   <= stat.empty;
			is_full    <= stat.full;
		end
	end

	`RFMU_ASSERT_IMP(a_count_range, 1'b1, count_q <= CW'(DEPTH), "count beyond depth")
	`RFMU_ASSERT_IMP(a_push_not_full, cmd.do_push, !stat.full, "push into full ring")
	`RFMU_ASSERT_IMP(a_pop_not_empty, cmd.do_pop, !stat.empty, "pop from empty ring")
	`RFMU_ASSERT_IMP(a_upd_on_hit, cmd.upd_write, stat.hit, "update write without a match")

endmodule

`default_nettype wire

@@ design/rfmu_ctrl.sv @@
// ring fifo controller: sequences push, pop, search and result handoff
// depends on rfmu_pkg
`default_nettype none
`include "ring_fifo_with_match_update_top_macros.svh"

module rfmu_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         action,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire rfmu_pkg::dp_stat_t stat,
	output rfmu_pkg::dp_cmd_t       cmd
);

	import rfmu_pkg::*;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_HEAD   = 2'd2;
	localparam logic [1:0] S_FIN    = 2'd3;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;
	logic       accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid & in_ready;
	assign out_valid = out_valid_q;

	// next state and datapath commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.capture   = 1'b1;
					cmd.status_wr = 1'b1;
					cmd.status    = ST_DONE;
					state_d       = S_HEAD;
					unique case (action)
						ACT_PUSH: begin
							if (stat.full) cmd.status = ST_FULL;
							else cmd.do_push = 1'b1;
						end
						ACT_POP: begin
							if (stat.empty) cmd.status = ST_EMPTY;
							else cmd.do_pop = 1'b1;
						end
						ACT_UPDATE: begin
							if (stat.empty) begin
								cmd.status = ST_EMPTY;
							end else begin
								cmd.scan_start = 1'b1;
								state_d        = S_SEARCH;
							end
						end
						default: ;
					endcase
				end
			end
			S_SEARCH: begin
				cmd.scan_step = 1'b1;
				if (stat.hit) begin
					cmd.upd_write = 1'b1;
					cmd.status_wr = 1'b1;
					cmd.status    = ST_DONE;
					state_d       = S_HEAD;
				end else if (stat.last) begin
					cmd.status_wr = 1'b1;
					cmd.status    = ST_MISSING;
					state_d       = S_HEAD;
				end
			end
			S_HEAD: begin
				cmd.head_read = 1'b1;
				state_d       = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_result = 1'b1;
					state_d         = S_IDLE;
				end
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	`RFMU_ASSERT_IMP(a_no_overrun, cmd.load_result, !out_valid_q || out_ready, "result overrun")
	`RFMU_ASSERT_NXT(a_accept_busy, accept, state_q != S_IDLE, "accepted transaction dropped")
	`RFMU_ASSERT_NXT(a_fin_holds, (state_q == S_FIN) && !cmd.load_result, state_q == S_FIN,
		"result stage left without handoff")

endmodule

`default_nettype wire

@@ design/ring_fifo_with_match_update_top.sv @@
// Ring FIFO with push, pop and match-update.
// Input channel (in_valid/in_ready) carries action, item_value and
// replacement_value; output channel (out_valid/out_ready) returns one result
// per input transaction: status, head_value, occupancy, is_empty, is_full.
// An input transaction is taken only when the controller is idle. Push, pop,
// refused actions and the unused action code go from acceptance through the
// head read and result stages into the output register, then the next
// transaction can be taken. An update walks the ring from head, one entry
// read from the ram per cycle, each read compared in the cycle after; it
// stops at the first match or reports a miss after the last stored entry.
// The result register decouples the sides: a new transaction is taken while
// the previous result still waits; if the receiver stalls, the block holds
// its finished result in the last stage until the output register frees up.
// Reset (arst_n low) empties the ring and clears the output valid flag at once;
// the entry ram is not cleared, entries are only used after being written.
// Depends on rfmu_pkg, rfmu_ctrl, rfmu_dp and rfmu_ram.
`default_nettype none

module ring_fifo_with_match_update_top #(
	parameter int DEPTH      = 128,
	parameter int DATA_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  action,
	input  wire logic [31:0] item_value,
	input  wire logic [31:0] replacement_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       status,
	output logic [31:0]      head_value,
	output logic [7:0]       occupancy,
	output logic             is_empty,
	output logic             is_full
);

	import rfmu_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer
	rfmu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// storage, pointers and result
	rfmu_dp #(
		.DEPTH     (DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.item_value       (item_value),
		.replacement_value(replacement_value),
		.cmd              (cmd),
		.stat             (stat),
		.status           (status),
		.head_value       (head_value),
		.occupancy        (occupancy),
		.is_empty         (is_empty),
		.is_full          (is_full)
	);

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// self-checking testbench for ring_fifo_with_match_update_top: push, pop and match-update traffic
// with random idling on both channels, checked against an in-bench model of the ring
// depends on rfmu_pkg and the ring_fifo_with_match_update_top rtl
module testbench;
	import rfmu_pkg::*;

	localparam int FIFO_DEPTH = 128;
	localparam logic [1:0] ACT_IGNORED = 2'd3;
	localparam int RANDOM_OPS = 1600;
	localparam int HOLD_CYCLES = 600;
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct packed {
		logic [1:0]  act;
		logic [31:0] key;
		logic [31:0] repl;
	} fifo_op_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] head_value;
		logic [7:0]  occupancy;
		logic        is_empty;
		logic        is_full;
	} fifo_view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] action = ACT_PUSH;
	logic [31:0] item_value = '0;
	logic [31:0] replacement_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] status;
	logic [31:0] head_value;
	logic [7:0] occupancy;
	logic is_empty;
	logic is_full;

	fifo_op_t op_queue[$];
	fifo_view_t due_results[$];
	logic [31:0] word_pool[8];
	bit mismatch = 1'b0;

	// model copy of the ring
	logic [31:0] ring_mem[FIFO_DEPTH];
	int unsigned ring_head = 0;
	int unsigned ring_tail = 0;
	int unsigned ring_count = 0;

	ring_fifo_with_match_update_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.item_value(item_value),
		.replacement_value(replacement_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.head_value(head_value),
		.occupancy(occupancy),
		.is_empty(is_empty),
		.is_full(is_full)
	);

	// clock, first edge at half a period
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// apply one operation to the model ring and return the fifo view afterwards
	function automatic fifo_view_t apply_fifo_op(fifo_op_t op);
		fifo_view_t view;
		int unsigned pos;
		bit hit;
		view.status = ST_DONE;
		case (op.act)
			ACT_PUSH: begin
				if (ring_count == FIFO_DEPTH) begin
					view.status = ST_FULL;
				end else begin
					ring_mem[ring_tail] = op.key;
					ring_tail = (ring_tail + 1) % FIFO_DEPTH;
					ring_count++;
				end
			end
			ACT_POP: begin
				if (ring_count == 0) begin
					view.status = ST_EMPTY;
				end else begin
					ring_head = (ring_head + 1) % FIFO_DEPTH;
					ring_count--;
				end
			end
			ACT_UPDATE: begin
				if (ring_count == 0) begin
					view.status = ST_EMPTY;
				end else begin
					// first match from head wins, full ring included
					hit = 1'b0;
					pos = ring_head;
					for (int n = 0; n < ring_count && !hit; n++) begin
						if (ring_mem[pos] == op.key) begin
							ring_mem[pos] = op.repl;
							hit = 1'b1;
						end
						pos = (pos + 1) % FIFO_DEPTH;
					end
					if (!hit)
						view.status = ST_MISSING;
				end
			end
			default: ;
		endcase
		view.head_value = (ring_count != 0) ? ring_mem[ring_head] : 32'd0;
		view.occupancy = ring_count[7:0];
		view.is_empty = (ring_count == 0);
		view.is_full = (ring_count == FIFO_DEPTH);
		return view;
	endfunction

	// idle length: mostly short, a few long, with idle-free stretches now and then
	function automatic int draw_gap(inout int calm_left);
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm_left = $urandom_range(20, 120);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// words from a small pool so that update keys hit often, plus extremes and noise
	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return word_pool[$urandom_range(0, 7)];
		if (r < 55)
			return 32'd0;
		if (r < 60)
			return 32'hFFFF_FFFF;
		return $urandom();
	endfunction

	function automatic void add_op(logic [1:0] act, logic [31:0] key, logic [31:0] repl);
		fifo_op_t op;
		op.act = act;
		op.key = key;
		op.repl = repl;
		op_queue.push_back(op);
	endfunction

	// mode 0 fills, 1 drains, 2 mixes, 3 leans on updates
	function automatic void add_random_op(int mode);
		int r;
		int push_pct;
		int pop_pct;
		r = $urandom_range(0, 99);
		case (mode)
			0: begin push_pct = 85; pop_pct = 5; end
			1: begin push_pct = 5; pop_pct = 85; end
			2: begin push_pct = 45; pop_pct = 35; end
			default: begin push_pct = 30; pop_pct = 20; end
		endcase
		if (r < push_pct)
			add_op(ACT_PUSH, pick_word(), $urandom());
		else if (r < push_pct + pop_pct)
			add_op(ACT_POP, $urandom(), $urandom());
		else if (r < 98)
			add_op(ACT_UPDATE, pick_word(), pick_word());
		else
			add_op(ACT_IGNORED, $urandom(), $urandom());
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch = 1'b1;
		end
	endfunction

	// stimulus and end of run
	initial begin
		int done_ops;
		int mode;
		int span;
		for (int i = 0; i < 8; i++)
			word_pool[i] = $urandom();

		// directed: empty refusals, ignored code, extremes, duplicates, hit and miss
		add_op(ACT_POP, 32'd0, 32'd0);
		add_op(ACT_UPDATE, 32'd0, 32'hFFFF_FFFF);
		add_op(ACT_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_op(ACT_PUSH, 32'd0, 32'hFFFF_FFFF);
		add_op(ACT_PUSH, 32'hFFFF_FFFF, 32'd0);
		add_op(ACT_PUSH, 32'h5A5A_5A5A, 32'd0);
		add_op(ACT_PUSH, 32'hFFFF_FFFF, 32'd0);
		add_op(ACT_UPDATE, 32'hFFFF_FFFF, 32'h1234_5678);
		add_op(ACT_UPDATE, 32'hFFFF_FFFF, 32'd0);
		add_op(ACT_UPDATE, 32'hDEAD_BEEF, 32'hA5A5_A5A5);
		add_op(ACT_UPDATE, 32'd0, 32'hFFFF_FFFF);
		add_op(ACT_IGNORED, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
		add_op(ACT_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_op(ACT_UPDATE, 32'd0, 32'd1);
		add_op(ACT_POP, 32'd0, 32'd0);
		add_op(ACT_POP, 32'd0, 32'd0);
		add_op(ACT_POP, 32'd0, 32'd0);
		add_op(ACT_POP, 32'd0, 32'd0);

		// random phases, the first one long enough to reach a full ring
		done_ops = 0;
		mode = 0;
		span = 170;
		while (done_ops < RANDOM_OPS) begin
			for (int i = 0; i < span; i++)
				add_random_op(mode);
			done_ops += span;
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (op_queue.size() != 0 || in_valid)
			@(negedge clk);
		while (due_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (!mismatch)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// driver: present queued operations, predict each accepted transaction
	int tx_gap = 0;
	int tx_calm = 0;
	always @(posedge clk) begin
		fifo_op_t taken;
		fifo_op_t nxt;
		logic nxt_valid;
		if (arst_n) begin
			nxt_valid = in_valid;
			if (in_valid && in_ready) begin
				taken.act = action;
				taken.key = item_value;
				taken.repl = replacement_value;
				due_results.push_back(apply_fifo_op(taken));
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
				end else if (op_queue.size() != 0) begin
					nxt = op_queue.pop_front();
					action <= nxt.act;
					item_value <= nxt.key;
					replacement_value <= nxt.repl;
					nxt_valid = 1'b1;
					tx_gap <= draw_gap(tx_calm);
				end
			end
			in_valid <= nxt_valid;
		end
	end

	// monitor: check each result transaction, random back-pressure and two long hold-offs
	always @(posedge clk) begin
		fifo_view_t want;
		logic nxt_ready;
		int g;
		static int rx_stall = 0;
		static int rx_calm = 0;
		static int n_results = 0;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$error("result with no transaction pending: status %0d, occupancy %0d",
						status, occupancy);
					mismatch = 1'b1;
				end else begin
					want = due_results.pop_front();
					check_field("status", want.status, status);
					check_field("head_value", want.head_value, head_value);
					check_field("occupancy", want.occupancy, occupancy);
					check_field("is_empty", want.is_empty, is_empty);
					check_field("is_full", want.is_full, is_full);
				end
				n_results++;
				// hold off long enough that the block backs up into its input
				if (n_results == 300 || n_results == 1100)
					rx_stall = HOLD_CYCLES;
			end
			if (rx_stall != 0) begin
				nxt_ready = 1'b0;
				rx_stall--;
			end else if ($urandom_range(0, 3) == 0) begin
				g = draw_gap(rx_calm);
				nxt_ready = (g == 0);
				rx_stall = (g != 0) ? g - 1 : 0;
			end else begin
				nxt_ready = 1'b1;
			end
			out_ready <= nxt_ready;
		end
	end

	// watchdog on cycles with no transaction on either channel
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == QUIET_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule
